[sv/scsa_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants for the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int SLOTS_PER_BLOCK  = 64;
    localparam int BLOCKS_PER_CLASS = 16;
    localparam int CLASS_COUNT      = 3;

    localparam int STACK_CAP  = SLOTS_PER_BLOCK * BLOCKS_PER_CLASS;
    localparam int MEM_DEPTH  = CLASS_COUNT * STACK_CAP;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int FILL_W     = $clog2(STACK_CAP + 1);
    localparam int BLK_W      = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int FRESH_W    = $clog2(SLOTS_PER_BLOCK + 1);

    // Field widths fixed by the interface
    localparam int SIZE_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int HANDLE_W   = 10;
    localparam int COUNT_W    = 11;
    localparam int CLS_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [LIMIT_W-1:0] LIMIT_SMALL_RST = 16'd24;
    localparam logic [LIMIT_W-1:0] LIMIT_MID_RST   = 16'd40;
    localparam logic [LIMIT_W-1:0] LIMIT_LARGE_RST = 16'd72;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_SMALL = 2'd0,
        CFG_LIMIT_MID   = 2'd1,
        CFG_LIMIT_LARGE = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_EXHAUST = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        opcode_t               op;
        logic                  nofit;
        logic [CLS_W-1:0]      cls;
        logic [HANDLE_W-1:0]   slot;
    } cmd_t;

endpackage

[sv/size_class_slab_allocator_core.sv]
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core
// Slab allocator over three size classes with per-class free stacks.
// ----------------------------------------------------------------------------
// The back-end sequencer handles each request in IDLE, then EXEC: IDLE reads
// the top of the class's free stack from the single-port stack memory, EXEC
// updates the class counters, writes a pushed handle and loads the result
// register. It takes no new request until EXEC is done with the last one,
// nor while an untaken result would be overwritten; the front classifies a
// request in the cycle it is accepted and parks it in a two-entry queue, so
// a new request can be accepted while a result waits on the output. The
// stack memory needs no clearing after reset: only entries below a class's
// fill level are ever used. Limits are to be written through the cfg port
// only while the block is idle (not enforced); index 0 small, 1 mid, 2 large.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [scsa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [scsa_pkg::LIMIT_W-1:0]    cfg_wdata,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [scsa_pkg::SIZE_W-1:0]     req_size,
    input  logic [scsa_pkg::HANDLE_W-1:0]   slot_in,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scsa_pkg::STATUS_W-1:0]   status,
    output logic [scsa_pkg::CLS_W-1:0]      size_class,
    output logic [scsa_pkg::HANDLE_W-1:0]   slot_out,
    output logic [scsa_pkg::COUNT_W-1:0]    live_now,
    output logic [scsa_pkg::COUNT_W-1:0]    live_peak
);

    scsa_pkg::cmd_t front_cmd;   // classified request, before the queue
    scsa_pkg::cmd_t q_cmd;       // head of the queue
    logic           q_valid;
    logic           q_pop;

    // Front: limit registers and class selection
    scsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .opcode    (opcode),
        .req_size  (req_size),
        .slot_in   (slot_in),
        .cmd       (front_cmd)
    );

    // Decoupling queue: input transfer happens whenever it has room
    scsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Back: stack memory, slot carving, counters, result register
    scsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .size_class (size_class),
        .slot_out   (slot_out),
        .live_now   (live_now),
        .live_peak  (live_peak)
    );

endmodule

[sv/scsa_front.sv]
// ----------------------------------------------------------------------------
// scsa_front
// Limit registers and size classification of incoming requests.
// ----------------------------------------------------------------------------
module scsa_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [scsa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [scsa_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic                            opcode,
    input  logic [scsa_pkg::SIZE_W-1:0]     req_size,
    input  logic [scsa_pkg::HANDLE_W-1:0]   slot_in,
    output scsa_pkg::cmd_t                  cmd
);

    logic [scsa_pkg::LIMIT_W-1:0] limit_small_reg;
    logic [scsa_pkg::LIMIT_W-1:0] limit_mid_reg;
    logic [scsa_pkg::LIMIT_W-1:0] limit_large_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_small_reg <= scsa_pkg::LIMIT_SMALL_RST;
            limit_mid_reg   <= scsa_pkg::LIMIT_MID_RST;
            limit_large_reg <= scsa_pkg::LIMIT_LARGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                scsa_pkg::CFG_LIMIT_SMALL: limit_small_reg <= cfg_wdata;
                scsa_pkg::CFG_LIMIT_MID:   limit_mid_reg   <= cfg_wdata;
                scsa_pkg::CFG_LIMIT_LARGE: limit_large_reg <= cfg_wdata;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // First class whose limit covers the size wins
    always_comb
    begin
        cmd.op    = scsa_pkg::opcode_t'(opcode);
        cmd.slot  = slot_in;
        cmd.nofit = 1'b0;
        if (req_size <= {{(scsa_pkg::SIZE_W-scsa_pkg::LIMIT_W){1'b0}}, limit_small_reg})
            cmd.cls = 2'd0;
        else if (req_size <= {{(scsa_pkg::SIZE_W-scsa_pkg::LIMIT_W){1'b0}}, limit_mid_reg})
            cmd.cls = 2'd1;
        else if (req_size <= {{(scsa_pkg::SIZE_W-scsa_pkg::LIMIT_W){1'b0}}, limit_large_reg})
            cmd.cls = 2'd2;
        else
        begin
            cmd.cls   = 2'd0;
            cmd.nofit = 1'b1;
        end
    end

endmodule

[sv/scsa_queue.sv]
// ----------------------------------------------------------------------------
// scsa_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module scsa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  scsa_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop,
    output scsa_pkg::cmd_t  pop_cmd
);

    scsa_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[sv/scsa_back.sv]
// ----------------------------------------------------------------------------
// scsa_back
// Two-step sequencer: per-class stacks, fresh-slot carving, live/peak counts,
// result register.
// ----------------------------------------------------------------------------
module scsa_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  scsa_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scsa_pkg::STATUS_W-1:0]   status,
    output logic [scsa_pkg::CLS_W-1:0]      size_class,
    output logic [scsa_pkg::HANDLE_W-1:0]   slot_out,
    output logic [scsa_pkg::COUNT_W-1:0]    live_now,
    output logic [scsa_pkg::COUNT_W-1:0]    live_peak
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    scsa_pkg::cmd_t item_reg;

    logic [scsa_pkg::FILL_W-1:0]  fill_reg  [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::BLK_W-1:0]   blk_reg   [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::FRESH_W-1:0] fresh_reg [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::COUNT_W-1:0] live_reg  [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::COUNT_W-1:0] peak_reg  [scsa_pkg::CLASS_COUNT];

    logic [scsa_pkg::HANDLE_W-1:0] stack_mem [scsa_pkg::MEM_DEPTH];
    logic [scsa_pkg::HANDLE_W-1:0] mem_rdata_reg;

    logic                          out_valid_reg;
    logic [scsa_pkg::STATUS_W-1:0] status_reg;
    logic [scsa_pkg::CLS_W-1:0]    class_reg;
    logic [scsa_pkg::HANDLE_W-1:0] slot_reg;
    logic [scsa_pkg::COUNT_W-1:0]  live_out_reg;
    logic [scsa_pkg::COUNT_W-1:0]  peak_out_reg;

    logic                          take;
    logic                          exec;
    logic [scsa_pkg::CLS_W-1:0]    cur_cls;
    logic [scsa_pkg::FILL_W-1:0]   cur_fill;
    logic [scsa_pkg::BLK_W-1:0]    cur_blk;
    logic [scsa_pkg::FRESH_W-1:0]  cur_fresh;
    logic [scsa_pkg::COUNT_W-1:0]  cur_live;
    logic [scsa_pkg::COUNT_W-1:0]  cur_peak;

    logic [scsa_pkg::FILL_W-1:0]   fill_next;
    logic [scsa_pkg::BLK_W-1:0]    blk_next;
    logic [scsa_pkg::FRESH_W-1:0]  fresh_next;
    logic [scsa_pkg::COUNT_W-1:0]  live_next;
    logic [scsa_pkg::COUNT_W-1:0]  peak_next;
    logic [scsa_pkg::BLK_W-1:0]    hblk;
    scsa_pkg::status_t             res_status;
    logic [scsa_pkg::HANDLE_W-1:0] res_slot;
    logic [scsa_pkg::COUNT_W-1:0]  res_live;
    logic [scsa_pkg::COUNT_W-1:0]  res_peak;
    logic                          mem_we;
    logic [scsa_pkg::ADDR_W-1:0]   mem_addr;

    // Output slot is free by the time EXEC loads it
    assign take  = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign exec  = (state_reg == S_EXEC);
    assign q_pop = take;

    // One class lookup per cycle: the waiting command in IDLE, the held one in EXEC
    assign cur_cls   = exec ? item_reg.cls : q_cmd.cls;
    assign cur_fill  = fill_reg[cur_cls];
    assign cur_blk   = blk_reg[cur_cls];
    assign cur_fresh = fresh_reg[cur_cls];
    assign cur_live  = live_reg[cur_cls];
    assign cur_peak  = peak_reg[cur_cls];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (take) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Stack address: top entry for the pop in IDLE, next free entry for the push in EXEC
    always_comb
    begin
        if (exec)
            mem_addr = scsa_pkg::ADDR_W'(32'(cur_cls) * scsa_pkg::STACK_CAP
                                         + 32'(cur_fill));
        else
            mem_addr = scsa_pkg::ADDR_W'(32'(cur_cls) * scsa_pkg::STACK_CAP
                                         + 32'(cur_fill) - 32'd1);
    end

    always_comb
    begin
        fill_next  = cur_fill;
        blk_next   = cur_blk;
        fresh_next = cur_fresh;
        live_next  = cur_live;
        peak_next  = cur_peak;
        hblk       = cur_blk - scsa_pkg::BLK_W'(1);
        res_status = scsa_pkg::ST_OK;
        res_slot   = '0;
        mem_we     = 1'b0;
        if (item_reg.nofit)
        begin
            res_status = scsa_pkg::ST_NOFIT;
            res_slot   = (item_reg.op == scsa_pkg::OP_FREE) ? item_reg.slot : '0;
        end
        else if (item_reg.op == scsa_pkg::OP_ALLOC)
        begin
            if (cur_fill != '0)
            begin
                fill_next = cur_fill - scsa_pkg::FILL_W'(1);
                res_slot  = mem_rdata_reg;
            end
            else if (cur_fresh == '0)
            begin
                if (32'(cur_blk) >= scsa_pkg::BLOCKS_PER_CLASS)
                    res_status = scsa_pkg::ST_EXHAUST;
                else
                begin
                    // open a new block and take its top slot
                    blk_next   = cur_blk + scsa_pkg::BLK_W'(1);
                    hblk       = cur_blk;
                    fresh_next = scsa_pkg::FRESH_W'(scsa_pkg::SLOTS_PER_BLOCK - 1);
                end
            end
            else
                fresh_next = cur_fresh - scsa_pkg::FRESH_W'(1);

            if (cur_fill == '0 && res_status == scsa_pkg::ST_OK)
                res_slot = scsa_pkg::HANDLE_W'(32'(hblk) * scsa_pkg::SLOTS_PER_BLOCK
                                               + 32'(fresh_next));
            if (res_status == scsa_pkg::ST_OK)
            begin
                if (cur_live < scsa_pkg::COUNT_MAX)
                    live_next = cur_live + scsa_pkg::COUNT_W'(1);
                if (live_next > cur_peak)
                    peak_next = live_next;
            end
        end
        else
        begin
            res_slot = item_reg.slot;
            if (32'(cur_fill) >= scsa_pkg::STACK_CAP)
                res_status = scsa_pkg::ST_FULL;
            else
            begin
                mem_we    = 1'b1;
                fill_next = cur_fill + scsa_pkg::FILL_W'(1);
                if (cur_live != '0)
                    live_next = cur_live - scsa_pkg::COUNT_W'(1);
            end
        end
        res_live = item_reg.nofit ? '0 : live_next;
        res_peak = item_reg.nofit ? '0 : peak_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < scsa_pkg::CLASS_COUNT; i++)
            begin
                fill_reg[i]  <= '0;
                blk_reg[i]   <= '0;
                fresh_reg[i] <= '0;
                live_reg[i]  <= '0;
                peak_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (exec && !item_reg.nofit)
            begin
                fill_reg[cur_cls]  <= fill_next;
                blk_reg[cur_cls]   <= blk_next;
                fresh_reg[cur_cls] <= fresh_next;
                live_reg[cur_cls]  <= live_next;
                peak_reg[cur_cls]  <= peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= q_cmd;
        if (exec)
        begin
            status_reg   <= res_status;
            class_reg    <= item_reg.cls;
            slot_reg     <= res_slot;
            live_out_reg <= res_live;
            peak_out_reg <= res_peak;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && mem_we)
            stack_mem[mem_addr] <= item_reg.slot;
        if (take)
            mem_rdata_reg <= stack_mem[mem_addr];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign size_class = class_reg;
    assign slot_out   = slot_reg;
    assign live_now   = live_out_reg;
    assign live_peak  = peak_out_reg;

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result loaded outside execute step");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (take && out_valid_reg) |-> out_ready)
        else $error("command taken while an untaken result would be overwritten");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg[0]) <= scsa_pkg::STACK_CAP && 32'(fill_reg[1]) <= scsa_pkg::STACK_CAP
        && 32'(fill_reg[2]) <= scsa_pkg::STACK_CAP)
        else $error("free stack fill beyond capacity");

    a_blocks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(blk_reg[0]) <= scsa_pkg::BLOCKS_PER_CLASS
        && 32'(blk_reg[1]) <= scsa_pkg::BLOCKS_PER_CLASS
        && 32'(blk_reg[2]) <= scsa_pkg::BLOCKS_PER_CLASS)
        else $error("opened block count beyond bound");

    a_peak_covers_live: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg[0] <= peak_reg[0] && live_reg[1] <= peak_reg[1]
        && live_reg[2] <= peak_reg[2])
        else $error("live count above recorded peak");

endmodule
